@@ design/rama_pkg.sv @@
// package for the rational add / multiply block: widths, microcode and control word types
`timescale 1ns / 1ps
`default_nettype none

package rama_pkg;

  localparam int IN_WIDTH  = 16;
  localparam int DEN_IN_W  = IN_WIDTH - 1;
  localparam int OUT_NUM_W = 32;
  localparam int OUT_DEN_W = 30;

  localparam int MUL_W  = IN_WIDTH + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 2 * IN_WIDTH;
  localparam int MAG_W  = 2 * IN_WIDTH;
  localparam int DEN_W  = 2 * IN_WIDTH - 2;
  localparam int CNT_W  = $clog2(MAG_W);
  localparam int K_W    = $clog2(MAG_W + 1);

  localparam int UC_DEPTH = 17;
  localparam int PC_W     = $clog2(UC_DEPTH);

  typedef logic [PC_W-1:0] upc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOADN,
    OP_ADDN,
    OP_LOADD,
    OP_GINIT,
    OP_HALVE_BOTH,
    OP_HALVE_X,
    OP_HALVE_Y,
    OP_SUBSWAP,
    OP_DIVINIT_NUM,
    OP_DIVSTEP,
    OP_DIVINIT_DEN,
    OP_FINISH,
    OP_OUT_DZ,
    OP_OUT_NZ
  } uop_t;

  typedef enum logic [1:0] {
    MS_FIRST,
    MS_BN_AD,
    MS_AD_BD
  } mulsel_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_DZERO,
    C_NZERO,
    C_BOTH_EVEN,
    C_X_EVEN,
    C_Y_EVEN,
    C_NE,
    C_CNT_NZ
  } cond_t;

  typedef struct packed {
    uop_t    op;
    mulsel_t msel;
    cond_t   cond;
    upc_t    target;
  } uword_t;

  // microcode addresses
  localparam upc_t A_START      = upc_t'(0);
  localparam upc_t A_LOADN      = upc_t'(1);
  localparam upc_t A_ADDN       = upc_t'(2);
  localparam upc_t A_LOADD      = upc_t'(3);
  localparam upc_t A_GINIT      = upc_t'(4);
  localparam upc_t A_ZCHK       = upc_t'(5);
  localparam upc_t A_HALVE_BOTH = upc_t'(6);
  localparam upc_t A_HALVE_X    = upc_t'(7);
  localparam upc_t A_HALVE_Y    = upc_t'(8);
  localparam upc_t A_SUBSWAP    = upc_t'(9);
  localparam upc_t A_DIVN_INIT  = upc_t'(10);
  localparam upc_t A_DIVN       = upc_t'(11);
  localparam upc_t A_DIVD_INIT  = upc_t'(12);
  localparam upc_t A_DIVD       = upc_t'(13);
  localparam upc_t A_FINISH     = upc_t'(14);
  localparam upc_t A_DZ         = upc_t'(15);
  localparam upc_t A_NZ         = upc_t'(16);

  function automatic uword_t uw(uop_t op, mulsel_t msel, cond_t cond, upc_t target);
    uword_t w;
    w.op     = op;
    w.msel   = msel;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // control store
  function automatic uword_t ucode(upc_t addr);
    uword_t w;
    case (addr)
      A_START:      w = uw(OP_NOP,         MS_FIRST, C_NEVER,     A_START);
      A_LOADN:      w = uw(OP_LOADN,       MS_BN_AD, C_NEVER,     A_START);
      A_ADDN:       w = uw(OP_ADDN,        MS_AD_BD, C_NEVER,     A_START);
      A_LOADD:      w = uw(OP_LOADD,       MS_FIRST, C_NEVER,     A_START);
      A_GINIT:      w = uw(OP_GINIT,       MS_FIRST, C_DZERO,     A_DZ);
      A_ZCHK:       w = uw(OP_NOP,         MS_FIRST, C_NZERO,     A_NZ);
      A_HALVE_BOTH: w = uw(OP_HALVE_BOTH,  MS_FIRST, C_BOTH_EVEN, A_HALVE_BOTH);
      A_HALVE_X:    w = uw(OP_HALVE_X,     MS_FIRST, C_X_EVEN,    A_HALVE_X);
      A_HALVE_Y:    w = uw(OP_HALVE_Y,     MS_FIRST, C_Y_EVEN,    A_HALVE_Y);
      A_SUBSWAP:    w = uw(OP_SUBSWAP,     MS_FIRST, C_NE,        A_HALVE_Y);
      A_DIVN_INIT:  w = uw(OP_DIVINIT_NUM, MS_FIRST, C_NEVER,     A_START);
      A_DIVN:       w = uw(OP_DIVSTEP,     MS_FIRST, C_CNT_NZ,    A_DIVN);
      A_DIVD_INIT:  w = uw(OP_DIVINIT_DEN, MS_FIRST, C_NEVER,     A_START);
      A_DIVD:       w = uw(OP_DIVSTEP,     MS_FIRST, C_CNT_NZ,    A_DIVD);
      A_FINISH:     w = uw(OP_FINISH,      MS_FIRST, C_NEVER,     A_START);
      A_DZ:         w = uw(OP_OUT_DZ,      MS_FIRST, C_NEVER,     A_START);
      A_NZ:         w = uw(OP_OUT_NZ,      MS_FIRST, C_NEVER,     A_START);
      default:      w = uw(OP_NOP,         MS_FIRST, C_NEVER,     A_START);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ design/rama_if.sv @@
// valid / ready channel interfaces for operand items and result items
`timescale 1ns / 1ps
`default_nettype none

interface rama_in_if
  import rama_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic signed [IN_WIDTH-1:0] a_num;
  logic        [DEN_IN_W-1:0] a_den;
  logic signed [IN_WIDTH-1:0] b_num;
  logic        [DEN_IN_W-1:0] b_den;

  modport source (output valid, mode, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rama_out_if
  import rama_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic signed [OUT_NUM_W-1:0] res_num;
  logic        [OUT_DEN_W-1:0] res_den;

  modport source (output valid, res_num, res_den, input ready);
  modport sink   (input valid, res_num, res_den, output ready);
endinterface

`default_nettype wire

@@ design/rational_add_multiply_reduce.sv @@
// top level: microcoded rational add / multiply with reduction to lowest terms
`timescale 1ns / 1ps
`default_nettype none

// Takes one item (mode, a_num/a_den, b_num/b_den) at a time and returns one reduced fraction
// with a positive denominator. A zero numerator gives 0/1, a zero denominator gives 0/0.
// A short microprogram drives one shared multiplier, a binary gcd unit (subtract and halve)
// and a one-bit-a-cycle restoring divider. Each item runs through the multiply steps, the two
// zero checks, the gcd loop (halving steps and subtract steps), two divisions by the gcd
// (numerator, then denominator) and a step that loads the result; a zero denominator or a
// zero numerator jumps from its zero check straight to the step that loads the result.
// The next item is taken as soon as the result is in the output register, even if that
// result has not yet been collected.
module rational_add_multiply_reduce
  import rama_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  rama_in_if.sink    in_ch,
  rama_out_if.source out_ch
);

  localparam int EXT_N = (MAG_W + 1 > OUT_NUM_W) ? MAG_W + 1 : OUT_NUM_W;
  localparam int EXT_D = (MAG_W > OUT_DEN_W) ? MAG_W : OUT_DEN_W;

  // sequencer
  logic   busy_r;
  upc_t   pc_r;
  upc_t   pc_nxt;
  uword_t uw_cur;
  logic   cond_hit;
  logic   fin;
  logic   stall;
  logic   adv;

  // captured operands
  logic                       mode_r;
  logic signed [IN_WIDTH-1:0] an_r;
  logic        [DEN_IN_W-1:0] ad_r;
  logic signed [IN_WIDTH-1:0] bn_r;
  logic        [DEN_IN_W-1:0] bd_r;

  // datapath
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [DEN_W-1:0]         den_r;
  logic [MAG_W-1:0]         mag_r;
  logic                     neg_r;
  logic [MAG_W-1:0]         gx_r;
  logic [MAG_W-1:0]         gy_r;
  logic [K_W-1:0]           k_r;
  logic [MAG_W-1:0]         div_r;
  logic [MAG_W-1:0]         q_r;
  logic [MAG_W-1:0]         rem_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [MAG_W:0]           div_sh;
  logic [MAG_W:0]           div_trial;
  logic                     div_ge;

  // result conversion
  logic signed [MAG_W:0]     snum;
  logic signed [EXT_N-1:0]   ext_num;
  logic        [EXT_D-1:0]   ext_den;

  // output register
  logic                        out_valid_r;
  logic signed [OUT_NUM_W-1:0] res_num_r;
  logic        [OUT_DEN_W-1:0] res_den_r;

  assign uw_cur = ucode(pc_r);
  assign fin    = (uw_cur.op == OP_FINISH) || (uw_cur.op == OP_OUT_DZ) ||
                  (uw_cur.op == OP_OUT_NZ);
  assign stall  = fin && out_valid_r && !out_ch.ready;
  assign adv    = busy_r && !stall;

  assign in_ch.ready    = !busy_r;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.res_num = res_num_r;
  assign out_ch.res_den = res_den_r;

  always_comb begin
    case (uw_cur.cond)
      C_NEVER:     cond_hit = 1'b0;
      C_DZERO:     cond_hit = (den_r == '0);
      C_NZERO:     cond_hit = (acc_r == '0);
      C_BOTH_EVEN: cond_hit = !gx_r[0] && !gy_r[0];
      C_X_EVEN:    cond_hit = !gx_r[0];
      C_Y_EVEN:    cond_hit = !gy_r[0];
      C_NE:        cond_hit = (gx_r != gy_r);
      C_CNT_NZ:    cond_hit = (cnt_r != '0);
      default:     cond_hit = 1'b0;
    endcase
    pc_nxt = cond_hit ? uw_cur.target : upc_t'(pc_r + 1'b1);
  end

  // shared multiplier operand selection
  always_comb begin
    case (uw_cur.msel)
      MS_FIRST: begin
        mul_a = MUL_W'(an_r);
        mul_b = mode_r ? MUL_W'(bn_r) : signed'({2'b00, bd_r});
      end
      MS_BN_AD: begin
        mul_a = MUL_W'(bn_r);
        mul_b = signed'({2'b00, ad_r});
      end
      MS_AD_BD: begin
        mul_a = signed'({2'b00, ad_r});
        mul_b = signed'({2'b00, bd_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // restoring division step
  assign div_sh    = {rem_r, q_r[MAG_W-1]};
  assign div_trial = div_sh - {1'b0, div_r};
  assign div_ge    = (div_sh >= {1'b0, div_r});

  assign snum    = neg_r ? -signed'({1'b0, mag_r}) : signed'({1'b0, mag_r});
  assign ext_num = EXT_N'(snum);
  assign ext_den = EXT_D'(q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= A_START;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        busy_r <= 1'b1;
        pc_r   <= A_START;
      end else if (adv) begin
        pc_r <= pc_nxt;
        if (fin) begin
          busy_r <= 1'b0;
        end
      end
      if (adv && fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      mode_r <= in_ch.mode;
      an_r   <= in_ch.a_num;
      ad_r   <= in_ch.a_den;
      bn_r   <= in_ch.b_num;
      bd_r   <= in_ch.b_den;
    end
    if (adv) begin
      prod_r <= mul_a * mul_b;
      case (uw_cur.op)
        OP_NOP: begin
        end
        OP_LOADN: begin
          acc_r <= prod_r[ACC_W-1:0];
        end
        OP_ADDN: begin
          if (!mode_r) begin
            acc_r <= acc_r + signed'(prod_r[ACC_W-1:0]);
          end
        end
        OP_LOADD: begin
          den_r <= prod_r[DEN_W-1:0];
        end
        OP_GINIT: begin
          neg_r <= acc_r[ACC_W-1];
          mag_r <= acc_r[ACC_W-1] ? MAG_W'(-acc_r) : MAG_W'(acc_r);
          gx_r  <= acc_r[ACC_W-1] ? MAG_W'(-acc_r) : MAG_W'(acc_r);
          gy_r  <= MAG_W'(den_r);
          k_r   <= '0;
        end
        OP_HALVE_BOTH: begin
          if (!gx_r[0] && !gy_r[0]) begin
            gx_r <= gx_r >> 1;
            gy_r <= gy_r >> 1;
            k_r  <= k_r + 1'b1;
          end
        end
        OP_HALVE_X: begin
          if (!gx_r[0]) begin
            gx_r <= gx_r >> 1;
          end
        end
        OP_HALVE_Y: begin
          if (!gy_r[0]) begin
            gy_r <= gy_r >> 1;
          end
        end
        OP_SUBSWAP: begin
          if (gx_r > gy_r) begin
            gx_r <= gy_r;
            gy_r <= gx_r - gy_r;
          end else begin
            gy_r <= gy_r - gx_r;
          end
        end
        OP_DIVINIT_NUM: begin
          div_r <= gx_r << k_r;
          q_r   <= mag_r;
          rem_r <= '0;
          cnt_r <= CNT_W'(MAG_W - 1);
        end
        OP_DIVSTEP: begin
          cnt_r <= cnt_r - 1'b1;
          if (div_ge) begin
            rem_r <= div_trial[MAG_W-1:0];
            q_r   <= {q_r[MAG_W-2:0], 1'b1};
          end else begin
            rem_r <= div_sh[MAG_W-1:0];
            q_r   <= {q_r[MAG_W-2:0], 1'b0};
          end
        end
        OP_DIVINIT_DEN: begin
          mag_r <= q_r;
          q_r   <= MAG_W'(den_r);
          rem_r <= '0;
          cnt_r <= CNT_W'(MAG_W - 1);
        end
        OP_FINISH: begin
          res_num_r <= ext_num[OUT_NUM_W-1:0];
          res_den_r <= ext_den[OUT_DEN_W-1:0];
        end
        OP_OUT_DZ: begin
          res_num_r <= '0;
          res_den_r <= '0;
        end
        OP_OUT_NZ: begin
          res_num_r <= '0;
          res_den_r <= OUT_DEN_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ test/tb_rational_add_multiply_reduce.sv @@
// testbench for the rational add / multiply block: directed and random fractions checked against a predictor
`timescale 1ns / 1ps

module tb_rational_add_multiply_reduce;
  import rama_pkg::*;

  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_MUL = 1'b1;

  localparam int RANDOM_ITEMS   = 1300;
  localparam int IDLE_PCT       = 38;
  localparam int HOLD_CYCLES    = 1500;
  localparam int DRAIN_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT = 6000;

  typedef longint unsigned u64_t;

  typedef struct {
    logic                       mode;
    logic signed [IN_WIDTH-1:0] a_num;
    logic        [DEN_IN_W-1:0] a_den;
    logic signed [IN_WIDTH-1:0] b_num;
    logic        [DEN_IN_W-1:0] b_den;
  } operand_t;

  typedef struct {
    logic signed [OUT_NUM_W-1:0] num;
    logic        [OUT_DEN_W-1:0] den;
  } fraction_t;

  class fraction_scoreboard;
    fraction_t   expected_q[$];
    int unsigned errors;
    int unsigned n_items;
    int unsigned n_add;
    int unsigned n_mul;
    int unsigned n_zero_den;
    int unsigned n_zero_num;
    int unsigned n_checked;

    function fraction_t reduce_fraction(operand_t op);
      fraction_t r;
      longint    num;
      u64_t      den;
      u64_t      mag;
      u64_t      x;
      u64_t      y;
      u64_t      t;
      den = u64_t'(op.a_den) * u64_t'(op.b_den);
      if (op.mode == MODE_ADD) begin
        num = longint'(op.a_num) * longint'(op.b_den) + longint'(op.b_num) * longint'(op.a_den);
      end else begin
        num = longint'(op.a_num) * longint'(op.b_num);
      end
      if (den == 0) begin
        r.num = '0;
        r.den = '0;
      end else if (num == 0) begin
        r.num = '0;
        r.den = OUT_DEN_W'(1);
      end else begin
        mag = (num < 0) ? u64_t'(-num) : u64_t'(num);
        x = mag;
        y = den;
        while (y != 0) begin
          t = x % y;
          x = y;
          y = t;
        end
        mag = mag / x;
        den = den / x;
        r.num = OUT_NUM_W'((num < 0) ? (u64_t'(0) - mag) : mag);
        r.den = OUT_DEN_W'(den);
      end
      return r;
    endfunction

    function void note_operands(operand_t op);
      fraction_t r;
      r = reduce_fraction(op);
      expected_q.push_back(r);
      n_items++;
      if (op.mode == MODE_ADD) n_add++;
      else n_mul++;
      if (r.den == 0) n_zero_den++;
      else if (r.num == 0) n_zero_num++;
    endfunction

    function void check_result(logic signed [OUT_NUM_W-1:0] num, logic [OUT_DEN_W-1:0] den);
      fraction_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %0d/%0d with nothing pending", $time, num, den);
        return;
      end
      e = expected_q.pop_front();
      n_checked++;
      if (num !== e.num) begin
        errors++;
        $display("%0t: res_num mismatch: expected %0d, actual %0d", $time, e.num, num);
      end
      if (den !== e.den) begin
        errors++;
        $display("%0t: res_den mismatch: expected %0d, actual %0d", $time, e.den, den);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic steady_flow   = 1'b0;
  logic hold_request  = 1'b0;
  logic hold_done     = 1'b0;
  int   quiet_cycles  = 0;

  fraction_scoreboard book = new();

  rama_in_if  in_ch ();
  rama_out_if out_ch ();

  rational_add_multiply_reduce u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic operand_t pack_operands(logic mode, int an, int ad, int bn, int bd);
    operand_t op;
    op.mode  = mode;
    op.a_num = IN_WIDTH'(an);
    op.a_den = DEN_IN_W'(ad);
    op.b_num = IN_WIDTH'(bn);
    op.b_den = DEN_IN_W'(bd);
    return op;
  endfunction

  function automatic int pick_extreme_num();
    case ($urandom_range(4))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      3:       return 1;
      default: return -1;
    endcase
  endfunction

  function automatic operand_t random_operands();
    operand_t    op;
    int unsigned kind;
    int          g;
    int          n;
    int          d;
    kind = $urandom_range(99);
    op.mode  = 1'($urandom_range(1));
    op.a_num = IN_WIDTH'($urandom);
    op.a_den = DEN_IN_W'($urandom);
    op.b_num = IN_WIDTH'($urandom);
    op.b_den = DEN_IN_W'($urandom);
    if (kind < 40) begin
      if (op.a_den == 0) op.a_den = DEN_IN_W'(1);
      if (op.b_den == 0) op.b_den = DEN_IN_W'(1);
    end else if (kind < 70) begin
      // small values so that reduction does real work
      op.a_num = IN_WIDTH'(int'($urandom_range(40)) - 20);
      op.a_den = DEN_IN_W'($urandom_range(30, 1));
      op.b_num = IN_WIDTH'(int'($urandom_range(40)) - 20);
      op.b_den = DEN_IN_W'($urandom_range(30, 1));
    end else if (kind < 82) begin
      // shared factors between numerators and denominators
      g = $urandom_range(180, 2);
      op.a_num = IN_WIDTH'(g * (int'($urandom_range(360)) - 180));
      op.a_den = DEN_IN_W'(g * int'($urandom_range(180, 1)));
      op.b_num = IN_WIDTH'(g * (int'($urandom_range(360)) - 180));
      op.b_den = DEN_IN_W'(g * int'($urandom_range(180, 1)));
    end else if (kind < 90) begin
      // zero numerator, from cancellation or, in multiply mode, from a zero operand
      n = int'($urandom_range(65535)) - 32768;
      d = $urandom_range(32767, 1);
      if ($urandom_range(1)) begin
        op.mode  = MODE_ADD;
        op.a_num = IN_WIDTH'(n == -32768 ? 32767 : n);
        op.b_num = -op.a_num;
        op.a_den = DEN_IN_W'(d);
        op.b_den = DEN_IN_W'(d);
      end else begin
        op.a_num = '0;
        op.a_den = DEN_IN_W'(d);
      end
    end else if (kind < 95) begin
      // zero denominator
      if ($urandom_range(1)) op.a_den = '0;
      else op.b_den = '0;
    end else begin
      op.a_num = IN_WIDTH'(pick_extreme_num());
      op.b_num = IN_WIDTH'(pick_extreme_num());
      op.a_den = $urandom_range(1) ? DEN_IN_W'(32767) : DEN_IN_W'(1);
      op.b_den = $urandom_range(1) ? DEN_IN_W'(32767) : DEN_IN_W'(1);
    end
    return op;
  endfunction

  task automatic offer_item(input operand_t op);
    in_ch.valid <= 1'b1;
    in_ch.mode  <= op.mode;
    in_ch.a_num <= op.a_num;
    in_ch.a_den <= op.a_den;
    in_ch.b_num <= op.b_num;
    in_ch.b_den <= op.b_den;
    do @(posedge clk); while (!in_ch.ready);
    if (!steady_flow) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // input acceptance feeds the predictor
  always @(posedge clk) begin
    operand_t seen;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen.mode  = in_ch.mode;
      seen.a_num = in_ch.a_num;
      seen.a_den = in_ch.a_den;
      seen.b_num = in_ch.b_num;
      seen.b_den = in_ch.b_den;
      book.note_operands(seen);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      book.check_result(out_ch.res_num, out_ch.res_den);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, book.pending());
      $display("Verification failed");
      $finish;
    end
  end

  // receiver, with one long hold-off so the block backs up
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        out_ch.ready <= 1'b0;
        hold_done = 1'b1;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    operand_t directed_q[$];
    in_ch.valid <= 1'b0;
    in_ch.mode  <= MODE_ADD;
    in_ch.a_num <= '0;
    in_ch.a_den <= '0;
    in_ch.b_num <= '0;
    in_ch.b_den <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_q.push_back(pack_operands(MODE_ADD, 1, 2, 1, 3));
    directed_q.push_back(pack_operands(MODE_MUL, 2, 4, 3, 9));
    directed_q.push_back(pack_operands(MODE_ADD, 1, 2, -1, 2));
    directed_q.push_back(pack_operands(MODE_MUL, 0, 5, 7, 3));
    directed_q.push_back(pack_operands(MODE_ADD, 3, 0, 5, 7));
    directed_q.push_back(pack_operands(MODE_MUL, 3, 4, 5, 0));
    directed_q.push_back(pack_operands(MODE_ADD, 0, 0, 0, 0));
    directed_q.push_back(pack_operands(MODE_MUL, -32768, 1, -32768, 1));
    directed_q.push_back(pack_operands(MODE_MUL, -32768, 32767, 32767, 32767));
    directed_q.push_back(pack_operands(MODE_ADD, -32768, 32767, -32768, 32767));
    directed_q.push_back(pack_operands(MODE_ADD, 32767, 32767, 32767, 32767));
    directed_q.push_back(pack_operands(MODE_MUL, 32767, 1, 32767, 1));
    directed_q.push_back(pack_operands(MODE_ADD, -1, 32767, 1, 32766));
    directed_q.push_back(pack_operands(MODE_MUL, -1, 1, -1, 1));
    directed_q.push_back(pack_operands(MODE_ADD, 32767, 1, -32768, 1));
    directed_q.push_back(pack_operands(MODE_ADD, 0, 32767, 0, 1));
    directed_q.push_back(pack_operands(MODE_MUL, 12345, 32767, -32768, 32766));
    directed_q.push_back(pack_operands(MODE_ADD, -32768, 2, -32768, 2));
    directed_q.push_back(pack_operands(MODE_MUL, 1, 32767, 1, 32767));
    directed_q.push_back(pack_operands(MODE_ADD, -32768, 32767, 32767, 1));
    foreach (directed_q[i]) offer_item(directed_q[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady_flow = (i >= 500 && i < 700);
      if (i == 250) hold_request = 1'b1;
      offer_item(random_operands());
    end
    steady_flow = 1'b0;
    in_ch.valid <= 1'b0;

    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d results from %0d items: %0d add, %0d multiply",
             book.n_checked, book.n_items, book.n_add, book.n_mul);
    $display("special cases seen: %0d zero denominators, %0d zero numerators, %0d errors",
             book.n_zero_den, book.n_zero_num, book.errors);
    if (book.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/rama_pkg.sv
design/rama_if.sv
design/rational_add_multiply_reduce.sv
test/tb_rational_add_multiply_reduce.sv
